/* hdl/ckhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Canonical k-mer hit counter package
// Command and status codes shared by the block.
// ----------------------------------------------------------------------------
package ckhc_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [2:0] status_type;

   localparam cmd_type CMD_LOAD       = 2'd0;
   localparam cmd_type CMD_SCAN       = 2'd1;
   localparam cmd_type CMD_READ_COUNT = 2'd2;
   localparam cmd_type CMD_READ_TOTAL = 2'd3;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_DUPLICATE = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_SHORT     = 3'd3;
   localparam status_type ST_HAS_N     = 3'd4;
   localparam status_type ST_MISS      = 3'd5;
   localparam status_type ST_HIT       = 3'd6;

   localparam int KEY_W   = 62;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = 48;
   localparam int RUN_W   = 6;
   localparam int OUT_IDX_W = 10;

endpackage
`default_nettype wire

/* hdl/canonical_kmer_hit_counter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// One item is in work at a time. A load or a scan searches the table one entry at a
// time through one comparator; a load that stores a key then clears its SAMPLES hit
// counters. A scan with a short window or an N, a total read and a read of an unloaded
// entry skip the search; a hit-count read reads the count memory. A stalled result item
// adds its wait.
// Reset is synchronous and active high; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
// Canonical k-mer hit counter
// Keeps a table of canonical target k-mers and counts window hits per sample.
// ----------------------------------------------------------------------------
module canonical_kmer_hit_counter_top #(
   parameter int K_MAX         = 31,
   parameter int TABLE_ENTRIES = 1024,
   parameter int SAMPLES       = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [4:0]             csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire ckhc_pkg::cmd_type      req_cmd,
   input  wire logic [61:0]            req_kmer_key,
   input  wire logic [2:0]             req_base,
   input  wire logic                   req_first_of_read,
   input  wire logic [1:0]             req_sample,
   input  wire logic [9:0]             req_entry,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output ckhc_pkg::status_type        rsp_status,
   output logic [9:0]                  rsp_entry_index,
   output logic [31:0]                 rsp_count_value,
   output logic [47:0]                 rsp_total_value
);
   import ckhc_pkg::*;

   localparam int WIN_W = 2 * K_MAX;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int SMP_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int CA_W  = $clog2(TABLE_ENTRIES * SAMPLES);
   localparam int CNT_ENTRIES = TABLE_ENTRIES * SAMPLES;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CANON    = 4'd1;
   localparam logic [3:0] S_SRCH_RD  = 4'd2;
   localparam logic [3:0] S_SRCH_CMP = 4'd3;
   localparam logic [3:0] S_CLEAR    = 4'd4;
   localparam logic [3:0] S_CNT_RD   = 4'd5;
   localparam logic [3:0] S_CNT_WR   = 4'd6;
   localparam logic [3:0] S_FINISH   = 4'd7;

   logic [3:0]           state_ff, state_in;
   logic [4:0]           klen_ff, klen_in;
   logic [WIN_W-1:0]     fwd_win_ff, fwd_win_in;
   logic [WIN_W-1:0]     rev_win_ff, rev_win_in;
   logic [RUN_W-1:0]     in_read_ff, in_read_in;
   logic [RUN_W-1:0]     since_n_ff, since_n_in;
   logic [IDX_W:0]       used_ff, used_in;
   logic [TOTAL_W-1:0]   totals_ff [SAMPLES];
   logic [TOTAL_W-1:0]   totals_in [SAMPLES];
   cmd_type              cmd_ff, cmd_in;
   logic [WIN_W-1:0]     key_ff, key_in;
   logic [1:0]           sample_ff, sample_in;
   logic [WIN_W-1:0]     canon_ff, canon_in;
   logic [IDX_W:0]       idx_ff, idx_in;
   logic [SMP_W:0]       clr_ff, clr_in;
   logic [CA_W-1:0]      cnt_addr_ff, cnt_addr_in;
   status_type           res_status_ff, res_status_in;
   logic [OUT_IDX_W-1:0] res_eidx_ff, res_eidx_in;
   logic [COUNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [9:0]           rsp_eidx_ff, rsp_eidx_in;
   logic [31:0]          rsp_cnt_ff, rsp_cnt_in;
   logic [47:0]          rsp_tot_ff, rsp_tot_in;

   logic [WIN_W-1:0]     key_table [TABLE_ENTRIES];
   logic [WIN_W-1:0]     key_rd_ff;
   logic                 key_we;
   logic [IDX_W-1:0]     key_addr;
   logic [COUNT_W-1:0]   cnt_mem [CNT_ENTRIES];
   logic [COUNT_W-1:0]   cnt_rd_ff;
   logic                 cnt_we;
   logic [COUNT_W-1:0]   cnt_wdata;

   logic [RUN_W-1:0]     k_eff;
   logic [WIN_W-1:0]     kmask;
   logic [WIN_W-1:0]     fwd_sel, rc_sel, rc_full;
   logic [1:0]           code, comp;
   logic                 is_acgt;
   logic                 req_accept;
   logic                 smp_ok;
   logic [SMP_W-1:0]     smp_idx;
   logic [COUNT_W-1:0]   cnt_inc;

   function automatic logic [WIN_W-1:0] rev_comp_full(input logic [WIN_W-1:0] f);
      logic [WIN_W-1:0] r;
      r = '0;
      for (int i = 0; i < K_MAX; i++) begin
         r[2*(K_MAX-1-i) +: 2] = ~f[2*i +: 2];
      end
      return r;
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   always_comb begin
      if (klen_ff == 5'd0) begin
         k_eff = RUN_W'(1);
      end else if (32'(klen_ff) > K_MAX) begin
         k_eff = RUN_W'(K_MAX);
      end else begin
         k_eff = RUN_W'(klen_ff);
      end
   end

   assign kmask   = ~({WIN_W{1'b1}} << (2 * k_eff));
   assign is_acgt = (req_base <= 3'd3);
   assign code    = is_acgt ? req_base[1:0] : 2'd0;
   assign comp    = is_acgt ? ~req_base[1:0] : 2'd0;
   assign rc_full = rev_comp_full(key_ff & kmask);
   assign fwd_sel = (cmd_ff == CMD_LOAD) ? (key_ff & kmask) : (fwd_win_ff & kmask);
   assign rc_sel  = (cmd_ff == CMD_LOAD) ? (rc_full >> (2 * (K_MAX - 32'(k_eff))))
                                         : (rev_win_ff >> (2 * (K_MAX - 32'(k_eff))));
   assign smp_ok  = (32'(sample_ff) < SAMPLES);
   assign smp_idx = SMP_W'(sample_ff);
   assign cnt_inc = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
   assign key_addr = key_we ? used_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      klen_in       = csr_wr_en ? csr_wr_data : klen_ff;
      fwd_win_in    = fwd_win_ff;
      rev_win_in    = rev_win_ff;
      in_read_in    = in_read_ff;
      since_n_in    = since_n_ff;
      used_in       = used_ff;
      totals_in     = totals_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      sample_in     = sample_ff;
      canon_in      = canon_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      cnt_addr_in   = cnt_addr_ff;
      res_status_in = res_status_ff;
      res_eidx_in   = res_eidx_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_eidx_in   = rsp_eidx_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_tot_in    = rsp_tot_ff;
      key_we        = 1'b0;
      cnt_we        = 1'b0;
      cnt_wdata     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_cmd;
               key_in        = WIN_W'(req_kmer_key);
               sample_in     = req_sample;
               res_status_in = ST_OK;
               res_eidx_in   = '0;
               res_cnt_in    = '0;
               case (req_cmd)
                  CMD_LOAD: begin
                     state_in = S_CANON;
                  end
                  CMD_SCAN: begin
                     if (req_first_of_read) begin
                        fwd_win_in = (WIN_W'(code));
                        rev_win_in = (WIN_W'(comp) << (WIN_W - 2));
                        in_read_in = RUN_W'(1);
                        since_n_in = is_acgt ? RUN_W'(1) : '0;
                     end else begin
                        fwd_win_in = (fwd_win_ff << 2) | WIN_W'(code);
                        rev_win_in = (rev_win_ff >> 2) | (WIN_W'(comp) << (WIN_W - 2));
                        in_read_in = (in_read_ff == RUN_MAX) ? in_read_ff : in_read_ff + 1'b1;
                        if (!is_acgt) begin
                           since_n_in = '0;
                        end else begin
                           since_n_in = (since_n_ff == RUN_MAX) ? since_n_ff
                                                                : since_n_ff + 1'b1;
                        end
                     end
                     if (in_read_in < k_eff) begin
                        res_status_in = ST_SHORT;
                        state_in      = S_FINISH;
                     end else begin
                        if ((32'(req_sample) < SAMPLES)
                            && (totals_ff[SMP_W'(req_sample)] != TOTAL_MAX)) begin
                           totals_in[SMP_W'(req_sample)] = totals_ff[SMP_W'(req_sample)] + 1'b1;
                        end
                        if (since_n_in < k_eff) begin
                           res_status_in = ST_HAS_N;
                           state_in      = S_FINISH;
                        end else begin
                           state_in = S_CANON;
                        end
                     end
                  end
                  CMD_READ_COUNT: begin
                     res_eidx_in = req_entry;
                     if ((32'(req_sample) < SAMPLES) && (32'(req_entry) < 32'(used_ff))) begin
                        cnt_addr_in = CA_W'(32'(req_entry) * SAMPLES + 32'(req_sample));
                        state_in    = S_CNT_RD;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_CANON: begin
            canon_in = (fwd_sel > rc_sel) ? fwd_sel : rc_sel;
            idx_in   = '0;
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            if (idx_ff == used_ff) begin
               if (cmd_ff == CMD_SCAN) begin
                  res_status_in = ST_MISS;
                  state_in      = S_FINISH;
               end else if (32'(used_ff) >= TABLE_ENTRIES) begin
                  res_status_in = ST_FULL;
                  state_in      = S_FINISH;
               end else begin
                  key_we        = 1'b1;
                  res_status_in = ST_OK;
                  res_eidx_in   = OUT_IDX_W'(used_ff);
                  used_in       = used_ff + 1'b1;
                  cnt_addr_in   = CA_W'(32'(used_ff) * SAMPLES);
                  clr_in        = '0;
                  state_in      = S_CLEAR;
               end
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (key_rd_ff == canon_ff) begin
               res_eidx_in = OUT_IDX_W'(idx_ff);
               if (cmd_ff == CMD_LOAD) begin
                  res_status_in = ST_DUPLICATE;
                  state_in      = S_FINISH;
               end else begin
                  res_status_in = ST_HIT;
                  if (smp_ok) begin
                     cnt_addr_in = CA_W'(32'(idx_ff) * SAMPLES + 32'(sample_ff));
                     state_in    = S_CNT_RD;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_wdata   = '0;
            cnt_addr_in = cnt_addr_ff + 1'b1;
            clr_in      = clr_ff + 1'b1;
            if (32'(clr_ff) == SAMPLES - 1) begin
               state_in = S_FINISH;
            end
         end
         S_CNT_RD: begin
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            if (cmd_ff == CMD_SCAN) begin
               cnt_we     = 1'b1;
               cnt_wdata  = cnt_inc;
               res_cnt_in = cnt_inc;
            end else begin
               res_cnt_in = cnt_rd_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_eidx_in   = res_eidx_ff;
               rsp_cnt_in    = res_cnt_ff;
               if (smp_ok && ((cmd_ff == CMD_SCAN) || (cmd_ff == CMD_READ_TOTAL))) begin
                  rsp_tot_in = totals_ff[smp_idx];
               end else begin
                  rsp_tot_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         klen_ff      <= 5'd31;
         fwd_win_ff   <= '0;
         rev_win_ff   <= '0;
         in_read_ff   <= '0;
         since_n_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SAMPLES; s++) begin
            totals_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         klen_ff      <= klen_in;
         fwd_win_ff   <= fwd_win_in;
         rev_win_ff   <= rev_win_in;
         in_read_ff   <= in_read_in;
         since_n_ff   <= since_n_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         totals_ff    <= totals_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      sample_ff     <= sample_in;
      canon_ff      <= canon_in;
      idx_ff        <= idx_in;
      clr_ff        <= clr_in;
      cnt_addr_ff   <= cnt_addr_in;
      res_status_ff <= res_status_in;
      res_eidx_ff   <= res_eidx_in;
      res_cnt_ff    <= res_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eidx_ff   <= rsp_eidx_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_tot_ff    <= rsp_tot_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_table[key_addr] <= canon_ff;
      end
      key_rd_ff <= key_table[key_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr_ff] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_addr_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_eidx_ff;
   assign rsp_count_value = rsp_cnt_ff;
   assign rsp_total_value = rsp_tot_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= TABLE_ENTRIES)
      else $error("Table fill count exceeds the table size.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("Block took an item and was not busy afterwards.");

   a_count_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_count_value != '0)) |->
         ((rsp_status == ST_HIT) || (rsp_status == ST_OK)))
      else $error("Nonzero count on an item that was neither a hit nor a read.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_HIT))
      else $error("Result item carries an undefined status.");

endmodule
`default_nettype wire
